FILE: hdl/sta_pkg.sv
// Shared types and constants for the scan-code to character FIFO unit.
// Used by the controller, the datapath and the top level; no dependencies.
package sta_pkg;

  localparam int DEF_FIFO_DEPTH = 64;

  localparam logic KIND_SCAN = 1'b0;
  localparam logic KIND_READ = 1'b1;

  typedef struct packed {
    logic load;
    logic exec;
    logic respond;
  } sta_cmd_t;

endpackage

FILE: hdl/scancode_to_ascii_fifo_unit.sv
// Top level of the scan-code to character FIFO unit.
// Instantiates sta_ctrl and sta_datapath; depends on sta_pkg.
//
// Usage: raise start with in_kind and in_scan_byte while busy is low; the
// item is taken at that edge. in_kind selects a scan-code byte (value 0, bit
// 7 marks a release) or a read of one buffered character. Each item gives
// exactly one result, shown on the out_ ports for one cycle while
// out_strobe is high, in the controller's result state. busy stays high
// from the cycle after acceptance through the result cycle,
// so a new item is taken only once the result cycle is over. The sequence
// is set by the controller: a load cycle, an execute cycle that updates the
// flags and the ring buffer and reads its memory port into a register, and
// a result cycle. The receiver cannot stall. cfg_we writes the snapshot
// make-code from cfg_wdata; raise it only while the unit is idle, which the
// block itself does not enforce. Synchronous reset empties the buffer,
// clears shift and caps lock, and sets the snapshot code to 0x3B; buffer
// memory contents are not cleared and need no clearing pass.
module scancode_to_ascii_fifo_unit
  import sta_pkg::*;
#(
  parameter int FIFO_DEPTH = DEF_FIFO_DEPTH
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  logic       in_kind,
  input  logic [7:0] in_scan_byte,
  input  logic       cfg_we,
  input  logic [6:0] cfg_wdata,
  output logic       out_strobe,
  output logic       out_char_valid,
  output logic [7:0] out_char_out,
  output logic       out_overwrote_oldest,
  output logic       out_snapshot_request,
  output logic [6:0] out_fill_count
);

  sta_cmd_t cmd;

  sta_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .cmd   (cmd)
  );

  sta_datapath #(
    .FIFO_DEPTH (FIFO_DEPTH)
  ) u_datapath (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd                  (cmd),
    .in_kind              (in_kind),
    .in_scan_byte         (in_scan_byte),
    .cfg_we               (cfg_we),
    .cfg_wdata            (cfg_wdata),
    .out_char_valid       (out_char_valid),
    .out_char_out         (out_char_out),
    .out_overwrote_oldest (out_overwrote_oldest),
    .out_snapshot_request (out_snapshot_request),
    .out_fill_count       (out_fill_count)
  );

  assign out_strobe = cmd.respond;

endmodule

FILE: hdl/sta_ctrl.sv
// Controller state machine of the scan-code to character FIFO unit.
// Sequences load, execute and respond; depends on sta_pkg.
module sta_ctrl
  import sta_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  output sta_cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_EXEC = 3'b010,
    S_RESP = 3'b100
  } state_t;

  state_t state_r;
  state_t state_nxt;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (start) state_nxt = S_EXEC;
      end
      S_EXEC: state_nxt = S_RESP;
      S_RESP: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy        = (state_r != S_IDLE);
  assign cmd.load    = (state_r == S_IDLE) && start;
  assign cmd.exec    = (state_r == S_EXEC);
  assign cmd.respond = (state_r == S_RESP);

`ifndef SYNTHESIS
  a_load_to_exec: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> cmd.exec) else $error("exec did not follow load");
  a_exec_to_resp: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec |=> cmd.respond) else $error("respond did not follow exec");
  a_resp_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.respond |=> !busy) else $error("controller did not return to idle");
`endif

endmodule

FILE: hdl/sta_datapath.sv
// Datapath of the scan-code to character FIFO unit: key flags, translation
// tables, character ring buffer with its pointers and the result registers.
// Depends on sta_pkg; driven by the commands of sta_ctrl.
module sta_datapath
  import sta_pkg::*;
#(
  parameter int FIFO_DEPTH = DEF_FIFO_DEPTH
) (
  input  logic       clk,
  input  logic       rst_n,
  input  sta_cmd_t   cmd,
  input  logic       in_kind,
  input  logic [7:0] in_scan_byte,
  input  logic       cfg_we,
  input  logic [6:0] cfg_wdata,
  output logic       out_char_valid,
  output logic [7:0] out_char_out,
  output logic       out_overwrote_oldest,
  output logic       out_snapshot_request,
  output logic [6:0] out_fill_count
);

  localparam int PTR_W = $clog2(FIFO_DEPTH);
  localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

  localparam logic [7:0] SC_LSHIFT = 8'h2A;
  localparam logic [7:0] SC_RSHIFT = 8'h36;
  localparam logic [7:0] SC_CAPS   = 8'h3A;
  localparam logic [7:0] CH_ESC    = 8'h1B;

  function automatic logic [7:0] key_char(input logic [6:0] code);
    logic [7:0] c;
    case (code)
      7'h01: c = 8'h1B;  7'h02: c = 8'h31;  7'h03: c = 8'h32;  7'h04: c = 8'h33;
      7'h05: c = 8'h34;  7'h06: c = 8'h35;  7'h07: c = 8'h36;  7'h08: c = 8'h37;
      7'h09: c = 8'h38;  7'h0A: c = 8'h39;  7'h0B: c = 8'h30;  7'h0C: c = 8'h2D;
      7'h0D: c = 8'h3D;  7'h0E: c = 8'h08;  7'h0F: c = 8'h09;  7'h10: c = 8'h71;
      7'h11: c = 8'h77;  7'h12: c = 8'h65;  7'h13: c = 8'h72;  7'h14: c = 8'h74;
      7'h15: c = 8'h79;  7'h16: c = 8'h75;  7'h17: c = 8'h69;  7'h18: c = 8'h6F;
      7'h19: c = 8'h70;  7'h1A: c = 8'h5B;  7'h1B: c = 8'h5D;  7'h1C: c = 8'h0A;
      7'h1E: c = 8'h61;  7'h1F: c = 8'h73;  7'h20: c = 8'h64;  7'h21: c = 8'h66;
      7'h22: c = 8'h67;  7'h23: c = 8'h68;  7'h24: c = 8'h6A;  7'h25: c = 8'h6B;
      7'h26: c = 8'h6C;  7'h27: c = 8'h3B;  7'h28: c = 8'h27;  7'h29: c = 8'h60;
      7'h2B: c = 8'h5C;  7'h2C: c = 8'h7A;  7'h2D: c = 8'h78;  7'h2E: c = 8'h63;
      7'h2F: c = 8'h76;  7'h30: c = 8'h62;  7'h31: c = 8'h6E;  7'h32: c = 8'h6D;
      7'h33: c = 8'h2C;  7'h34: c = 8'h2E;  7'h35: c = 8'h2F;  7'h37: c = 8'h2A;
      7'h39: c = 8'h20;  7'h47: c = 8'h37;  7'h48: c = 8'h38;  7'h49: c = 8'h39;
      7'h4A: c = 8'h2D;  7'h4B: c = 8'h34;  7'h4C: c = 8'h35;  7'h4D: c = 8'h36;
      7'h4E: c = 8'h2B;  7'h4F: c = 8'h31;  7'h50: c = 8'h32;  7'h51: c = 8'h33;
      7'h52: c = 8'h30;  7'h53: c = 8'h2E;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] shifted_sym(input logic [7:0] ch);
    logic [7:0] s;
    case (ch)
      8'h31: s = 8'h21;  8'h32: s = 8'h40;  8'h33: s = 8'h23;  8'h34: s = 8'h24;
      8'h35: s = 8'h25;  8'h36: s = 8'h5E;  8'h37: s = 8'h26;  8'h38: s = 8'h2A;
      8'h39: s = 8'h28;  8'h30: s = 8'h29;  8'h2D: s = 8'h5F;  8'h3D: s = 8'h2B;
      8'h5B: s = 8'h7B;  8'h5D: s = 8'h7D;  8'h5C: s = 8'h7C;  8'h3B: s = 8'h3A;
      8'h27: s = 8'h22;  8'h2C: s = 8'h3C;  8'h2E: s = 8'h3E;  8'h2F: s = 8'h3F;
      8'h60: s = 8'h7E;
      default: s = 8'h00;
    endcase
    return s;
  endfunction

  function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(FIFO_DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  logic [7:0]       char_store [FIFO_DEPTH];
  logic [7:0]       rd_data_r;
  logic             kind_r;
  logic [7:0]       byte_r;
  logic [6:0]       snap_code_r;
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] held_count_r, held_count_nxt;
  logic             shift_r, shift_nxt;
  logic             caps_r, caps_nxt;
  logic             valid_r, valid_nxt;
  logic             over_r, over_nxt;
  logic             snap_r, snap_nxt;
  logic             mem_we;
  logic             mem_re;
  logic [7:0]       base_char;
  logic [7:0]       sym_char;
  logic [7:0]       tr_char;

  always_comb begin
    base_char = key_char(byte_r[6:0]);
    sym_char  = shifted_sym(base_char);
    tr_char   = base_char;
    if (base_char inside {[8'h61:8'h7A]}) begin
      if (shift_r ^ caps_r) tr_char = base_char - 8'h20;
    end else if (shift_r && (sym_char != 8'h00)) begin
      tr_char = sym_char;
    end
    if (tr_char == CH_ESC) tr_char = 8'h00;
  end

  always_comb begin
    wr_ptr_nxt     = wr_ptr_r;
    rd_ptr_nxt     = rd_ptr_r;
    held_count_nxt = held_count_r;
    shift_nxt      = shift_r;
    caps_nxt       = caps_r;
    valid_nxt      = valid_r;
    over_nxt       = over_r;
    snap_nxt       = snap_r;
    mem_we         = 1'b0;
    mem_re         = 1'b0;
    if (cmd.exec) begin
      valid_nxt = 1'b0;
      over_nxt  = 1'b0;
      snap_nxt  = 1'b0;
      if (kind_r == KIND_READ) begin
        if (held_count_r != '0) begin
          mem_re         = 1'b1;
          valid_nxt      = 1'b1;
          rd_ptr_nxt     = next_slot(rd_ptr_r);
          held_count_nxt = held_count_r - CNT_W'(1);
        end
      end else if (byte_r[7]) begin
        if (({1'b0, byte_r[6:0]} == SC_LSHIFT) || ({1'b0, byte_r[6:0]} == SC_RSHIFT))
          shift_nxt = 1'b0;
      end else if (byte_r == {1'b0, snap_code_r}) begin
        snap_nxt = 1'b1;
      end else if (byte_r == SC_CAPS) begin
        caps_nxt = !caps_r;
      end else if ((byte_r == SC_LSHIFT) || (byte_r == SC_RSHIFT)) begin
        shift_nxt = 1'b1;
      end else if (tr_char != 8'h00) begin
        mem_we     = 1'b1;
        wr_ptr_nxt = next_slot(wr_ptr_r);
        if (held_count_r < CNT_W'(FIFO_DEPTH)) begin
          held_count_nxt = held_count_r + CNT_W'(1);
        end else begin
          rd_ptr_nxt = next_slot(rd_ptr_r);
          over_nxt   = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) char_store[wr_ptr_r] <= tr_char;
    if (mem_re) rd_data_r <= char_store[rd_ptr_r];
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r <= in_kind;
      byte_r <= in_scan_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      snap_code_r  <= 7'd59;
      wr_ptr_r     <= '0;
      rd_ptr_r     <= '0;
      held_count_r <= '0;
      shift_r      <= 1'b0;
      caps_r       <= 1'b0;
      valid_r      <= 1'b0;
      over_r       <= 1'b0;
      snap_r       <= 1'b0;
    end else begin
      if (cfg_we) snap_code_r <= cfg_wdata;
      wr_ptr_r     <= wr_ptr_nxt;
      rd_ptr_r     <= rd_ptr_nxt;
      held_count_r <= held_count_nxt;
      shift_r      <= shift_nxt;
      caps_r       <= caps_nxt;
      valid_r      <= valid_nxt;
      over_r       <= over_nxt;
      snap_r       <= snap_nxt;
    end
  end

  assign out_char_valid       = valid_r;
  assign out_char_out         = valid_r ? rd_data_r : 8'h00;
  assign out_overwrote_oldest = over_r;
  assign out_snapshot_request = snap_r;
  assign out_fill_count       = 7'(held_count_r);

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    held_count_r <= CNT_W'(FIFO_DEPTH)) else $error("fill count above depth");
  a_over_full: assert property (@(posedge clk) disable iff (!rst_n)
    over_r |-> (held_count_r == CNT_W'(FIFO_DEPTH)) && (wr_ptr_r == rd_ptr_r))
    else $error("overwrite flagged while buffer not full");
  a_scan_no_char: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec && (kind_r == KIND_SCAN) |=> !valid_r)
    else $error("character returned for a scan code item");
  a_read_pop: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec && (kind_r == KIND_READ) && (held_count_r != '0)
    |=> valid_r && (held_count_r == $past(held_count_r) - CNT_W'(1)))
    else $error("read did not pop one character");
`endif

endmodule
